[hdl/gbs_pkg.sv]
// Shared types and constants for greedy box suppression.
`default_nettype none
package gbs_pkg;

  localparam int MAX_KEPT    = 128;
  localparam int COORD_BITS  = 13;
  localparam int IDX_W       = $clog2(MAX_KEPT);
  localparam int CNT_W       = 8;
  localparam int RANK_W      = 8;
  localparam int THR_W       = 16;
  localparam int LIMIT_W     = 8;
  localparam int AREA_BITS   = 2 * COORD_BITS;
  localparam int UNI_W       = AREA_BITS + 1;
  localparam int EDGE_W      = COORD_BITS + 2;
  localparam int DIFF_W      = EDGE_W + 1;

  // stored entry layout
  localparam int LEFT_LSB    = 0;
  localparam int TOP_LSB     = COORD_BITS;
  localparam int WIDTH_LSB   = 2 * COORD_BITS;
  localparam int HEIGHT_LSB  = 3 * COORD_BITS;
  localparam int AREA_LSB    = 4 * COORD_BITS;
  localparam int ENTRY_BITS  = 4 * COORD_BITS + AREA_BITS;

  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = RANK_W + CNT_W;
  localparam int CFG_W       = THR_W;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(19661);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
  localparam logic [RANK_W-1:0]  RANK_MAX    = {RANK_W{1'b1}};

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_MAX_ITEMS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } cmp_res_t;

endpackage
`default_nettype wire

[hdl/gbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/gbs_overlap.sv]
// Pipelined IoU test of the current box against one stored box per cycle.
`default_nettype none
module gbs_overlap (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  flush,
  input  wire logic                                  in_valid,
  input  wire logic signed [gbs_pkg::COORD_BITS-1:0] cur_left,
  input  wire logic signed [gbs_pkg::COORD_BITS-1:0] cur_top,
  input  wire logic        [gbs_pkg::COORD_BITS-1:0] cur_width,
  input  wire logic        [gbs_pkg::COORD_BITS-1:0] cur_height,
  input  wire logic        [gbs_pkg::AREA_BITS-1:0]  cur_area,
  input  wire logic        [gbs_pkg::THR_W-1:0]      threshold,
  input  wire logic        [gbs_pkg::ENTRY_BITS-1:0] entry,
  output gbs_pkg::cmp_res_t                          res
);

  localparam int CB  = gbs_pkg::COORD_BITS;
  localparam int EW  = gbs_pkg::EDGE_W;
  localparam int DW  = gbs_pkg::DIFF_W;
  localparam int AB  = gbs_pkg::AREA_BITS;
  localparam int UW  = gbs_pkg::UNI_W;
  localparam int TW  = gbs_pkg::THR_W;
  localparam int PW  = TW + UW;

  logic signed [CB-1:0] k_left, k_top;
  logic        [CB-1:0] k_width, k_height;
  logic        [AB-1:0] k_area;

  logic signed [EW-1:0] cl, ct, cr, cb, kl, kt, kr, kb;
  logic signed [EW-1:0] x1, y1, x2, y2;
  logic signed [DW-1:0] dx, dy;

  logic          v1, v2, v3, v4;
  logic [CB-1:0] s1_dx, s1_dy;
  logic [AB-1:0] s1_karea, s2_karea, s2_inter, s3_inter;
  logic [UW-1:0] s3_uni;
  logic [PW-1:0] s4_rhs, s4_lhs;
  logic          s4_zero;
  logic          res_valid, res_hit;

  assign k_left   = entry[gbs_pkg::LEFT_LSB   +: CB];
  assign k_top    = entry[gbs_pkg::TOP_LSB    +: CB];
  assign k_width  = entry[gbs_pkg::WIDTH_LSB  +: CB];
  assign k_height = entry[gbs_pkg::HEIGHT_LSB +: CB];
  assign k_area   = entry[gbs_pkg::AREA_LSB   +: AB];

  always_comb begin
    cl = {{2{cur_left[CB-1]}}, cur_left};
    ct = {{2{cur_top[CB-1]}}, cur_top};
    kl = {{2{k_left[CB-1]}}, k_left};
    kt = {{2{k_top[CB-1]}}, k_top};
    cr = cl + {2'b00, cur_width};
    cb = ct + {2'b00, cur_height};
    kr = kl + {2'b00, k_width};
    kb = kt + {2'b00, k_height};
    x1 = (cl > kl) ? cl : kl;
    y1 = (ct > kt) ? ct : kt;
    x2 = (cr < kr) ? cr : kr;
    y2 = (cb < kb) ? cb : kb;
    dx = {x2[EW-1], x2} - {x1[EW-1], x1};
    dy = {y2[EW-1], y2} - {y1[EW-1], y1};
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      res_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // empty overlap in either axis gives zero intersection
    if (dx > 0 && dy > 0) begin
      s1_dx <= dx[CB-1:0];
      s1_dy <= dy[CB-1:0];
    end else begin
      s1_dx <= '0;
      s1_dy <= '0;
    end
    s1_karea <= k_area;

    s2_inter <= s1_dx * s1_dy;
    s2_karea <= s1_karea;

    s3_uni   <= {1'b0, cur_area} + {1'b0, s2_karea} - {1'b0, s2_inter};
    s3_inter <= s2_inter;

    s4_rhs   <= {{UW{1'b0}}, threshold} * {{TW{1'b0}}, s3_uni};
    s4_lhs   <= {{(PW-AB-TW){1'b0}}, s3_inter, {TW{1'b0}}};
    s4_zero  <= (s3_uni == '0);

    res_hit  <= s4_zero || (s4_lhs > s4_rhs);
  end

  assign res = '{valid: res_valid, hit: res_hit};

endmodule
`default_nettype wire

[hdl/greedy_box_suppression.sv]
// Greedy IoU non-maximum suppression over confidence-sorted boxes.
//
//  channel  dir  fields (low bit first)
//  s_*      in   tuser: starts_frame; tdata: box_left, box_top, box_width, box_height
//  m_*      out  tuser: kept, dropped_by_limit; tdata: item_rank, kept_total
//  cfg_*    in   index 0 overlap_threshold, index 1 max_items
//
//  An item compares its box with the stored boxes in order until the first hit (all
//  kept boxes if none hits): one stored box is read per cycle from the kept-box RAM
//  and fed to a five-stage IoU pipeline; limited items and items in an empty frame
//  skip the scan and go straight to the output.
//  Reset empties the frame and loads the register defaults; the RAM is not cleared.
//  A new word is taken while the previous result waits on m_tready.
`default_nettype none
module greedy_box_suppression (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [gbs_pkg::IN_TDATA_W-1:0]    s_tdata,  // left, top, width, height
  input  wire logic                              s_tuser,  // starts_frame
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [gbs_pkg::OUT_TDATA_W-1:0]   m_tdata,  // item_rank, kept_total
  output logic      [1:0]                        m_tuser,  // kept, dropped_by_limit
  input  wire logic                              cfg_we,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [gbs_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CB = gbs_pkg::COORD_BITS;
  localparam int CW = gbs_pkg::CNT_W;
  localparam int RW = gbs_pkg::RANK_W;

  gbs_pkg::state_t state, state_next;

  logic [gbs_pkg::THR_W-1:0]   threshold;
  logic [gbs_pkg::LIMIT_W-1:0] max_items;

  logic [CW-1:0] kept_count;
  logic [RW-1:0] rank_counter;
  logic [CW-1:0] issue_cnt, done_cnt;
  logic          hit, limited, rd_valid;

  logic signed [CB-1:0]            cur_left, cur_top;
  logic        [CB-1:0]            cur_width, cur_height;
  logic        [gbs_pkg::AREA_BITS-1:0] cur_area;
  logic        [RW-1:0]            cur_rank;

  logic          out_kept, out_limited;
  logic [RW-1:0] out_rank;
  logic [CW-1:0] out_total;

  logic          accept, issue, scan_done, finish_go, keep, flush;
  logic [CW-1:0] cnt_eff;
  logic [RW-1:0] rank_eff;
  logic          limit_now;
  logic [CW-1:0] done_next;

  logic [gbs_pkg::ENTRY_BITS-1:0] ram_wdata, ram_rdata;
  gbs_pkg::cmp_res_t              cmp_res;

  assign accept    = s_tvalid && s_tready;
  assign cnt_eff   = s_tuser ? '0 : kept_count;
  assign rank_eff  = s_tuser ? '0 : rank_counter;
  assign limit_now = (rank_eff >= max_items) || (cnt_eff >= CW'(gbs_pkg::MAX_KEPT));
  assign done_next = done_cnt + CW'(1);
  assign keep      = !limited && !hit;
  assign flush     = scan_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    issue      = 1'b0;
    scan_done  = 1'b0;
    finish_go  = 1'b0;
    unique case (state)
      gbs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (limit_now || cnt_eff == '0) ? gbs_pkg::ST_FINISH : gbs_pkg::ST_SCAN;
        end
      end
      gbs_pkg::ST_SCAN: begin
        issue = (issue_cnt != kept_count);
        if (cmp_res.valid && (cmp_res.hit || done_next == kept_count)) begin
          scan_done  = 1'b1;
          state_next = gbs_pkg::ST_FINISH;
        end
      end
      gbs_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          finish_go  = 1'b1;
          state_next = gbs_pkg::ST_IDLE;
        end
      end
      default: state_next = gbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbs_pkg::THR_RESET;
      max_items <= gbs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbs_pkg::REG_THRESHOLD: threshold <= cfg_data;
        gbs_pkg::REG_MAX_ITEMS: max_items <= cfg_data[gbs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count   <= '0;
      rank_counter <= '0;
      issue_cnt    <= '0;
      done_cnt     <= '0;
      hit          <= 1'b0;
      limited      <= 1'b0;
      rd_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      rd_valid <= issue && !flush;
      if (accept) begin
        kept_count   <= cnt_eff;
        rank_counter <= (rank_eff == gbs_pkg::RANK_MAX) ? rank_eff : rank_eff + RW'(1);
        limited      <= limit_now;
        issue_cnt    <= '0;
        done_cnt     <= '0;
        hit          <= 1'b0;
      end
      if (issue) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (state == gbs_pkg::ST_SCAN && cmp_res.valid) begin
        done_cnt <= done_next;
        if (cmp_res.hit) begin
          hit <= 1'b1;
        end
      end
      if (finish_go) begin
        m_tvalid <= 1'b1;
        if (keep) begin
          kept_count <= kept_count + CW'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_left   <= s_tdata[gbs_pkg::LEFT_LSB   +: CB];
      cur_top    <= s_tdata[gbs_pkg::TOP_LSB    +: CB];
      cur_width  <= s_tdata[gbs_pkg::WIDTH_LSB  +: CB];
      cur_height <= s_tdata[gbs_pkg::HEIGHT_LSB +: CB];
      cur_area   <= s_tdata[gbs_pkg::WIDTH_LSB +: CB] * s_tdata[gbs_pkg::HEIGHT_LSB +: CB];
      cur_rank   <= rank_eff;
    end
    if (finish_go) begin
      out_kept    <= keep;
      out_limited <= limited;
      out_rank    <= cur_rank;
      out_total   <= keep ? kept_count + CW'(1) : kept_count;
    end
  end

  assign ram_wdata = {cur_area, cur_height, cur_width, cur_top, cur_left};

  // writes happen only after the scan has ended, so no read overlaps a write
  gbs_ram #(
    .WIDTH (gbs_pkg::ENTRY_BITS),
    .DEPTH (gbs_pkg::MAX_KEPT)
  ) u_kept_ram (
    .clk   (clk),
    .we    (finish_go && keep),
    .waddr (kept_count[gbs_pkg::IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (issue_cnt[gbs_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  gbs_overlap u_overlap (
    .clk        (clk),
    .rst        (rst),
    .flush      (flush),
    .in_valid   (rd_valid),
    .cur_left   (cur_left),
    .cur_top    (cur_top),
    .cur_width  (cur_width),
    .cur_height (cur_height),
    .cur_area   (cur_area),
    .threshold  (threshold),
    .entry      (ram_rdata),
    .res        (cmp_res)
  );

  assign m_tdata = {out_total, out_rank};
  assign m_tuser = {out_limited, out_kept};

`ifndef NO_ASSERTIONS
  a_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_res.valid |-> state == gbs_pkg::ST_SCAN)
    else $error("compare result outside scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(gbs_pkg::MAX_KEPT))
    else $error("kept count beyond store size");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (finish_go && keep) |-> !issue && !rd_valid)
    else $error("store write during scan");

  a_done_le_issue: assert property (@(posedge clk) disable iff (rst)
    state == gbs_pkg::ST_SCAN |-> done_cnt <= issue_cnt && issue_cnt <= kept_count)
    else $error("scan counters out of order");

  a_kept_not_limited: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !(m_tuser[0] && m_tuser[1]))
    else $error("kept and limited both set");
`endif

endmodule
`default_nettype wire
